// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge outside of reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/fscdf_pkg.sv =====
// types, character codes and helpers for the framed sentence deframer
// no dependencies; used by framed_sentence_checksum_deframer
package fscdf_pkg;

   // framing characters
   localparam logic [7:0] ChStart   = 8'h24;  // '$'
   localparam logic [7:0] ChStar    = 8'h2A;  // '*'
   localparam logic [7:0] ChNewline = 8'h0A;  // '\n'
   localparam logic [7:0] ChDet     = 8'h45;  // 'E'
   localparam logic [7:0] ChCha     = 8'h48;  // 'H'
   localparam logic [7:0] ChCoo     = 8'h4F;  // 'O'
   localparam logic [7:0] ChHit     = 8'h49;  // 'I'

   // per-beat status codes
   typedef enum logic [2:0] {
      ST_WAITING = 3'd0,
      ST_GOOD    = 3'd1,
      ST_FAIL    = 3'd2,
      ST_DET     = 3'd3,
      ST_CHA     = 3'd4,
      ST_COO     = 3'd5,
      ST_HIT     = 3'd6
   } status_type;

   // framing phase, one-hot
   typedef enum logic [4:0] {
      PH_WAIT = 5'b00001,
      PH_REC  = 5'b00010,
      PH_HEX1 = 5'b00100,
      PH_HEX2 = 5'b01000,
      PH_NL   = 5'b10000
   } phase_type;

   // decoded hex digit
   typedef struct packed {
      logic       ok;
      logic [3:0] nib;
   } hex_type;

   // ascii hex digit to nibble, either case
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok  = 1'b1;
      h.nib = c[3:0];
      if (c >= 8'h30 && c <= 8'h39) begin
         h.nib = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         h.nib = c[3:0] + 4'd9;
      end else begin
         h.ok  = 1'b0;
         h.nib = 4'd0;
      end
      return h;
   endfunction

   // sentence kind from its second payload character
   function automatic status_type classify(input logic [7:0] k);
      status_type s;
      case (k)
         ChDet:   s = ST_DET;
         ChCha:   s = ST_CHA;
         ChCoo:   s = ST_COO;
         ChHit:   s = ST_HIT;
         default: s = ST_FAIL;
      endcase
      return s;
   endfunction

endpackage

// ===== hw/rtl/framed_sentence_checksum_deframer.sv =====
// each beat's result is registered into the result register, or into the skid entry while rsp stalls
// throughput: one character per cycle while req_tready is high; the framing state updates in one pass per beat
// a two-entry output stage (result register plus skid) lets req keep flowing for
// one more beat while rsp stalls; req_tready drops only while the skid entry is held
// reset (synchronous, active high) returns to waiting for '$' with counters cleared
// depends on fscdf_pkg and assert_macros.svh
`include "assert_macros.svh"

module framed_sentence_checksum_deframer #(
   parameter int MAX_PAYLOAD = 128
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_char
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [2:0] status, [10:3] payload_length, rest zero
);

   localparam logic [7:0] MaxPayloadLim = 8'(MAX_PAYLOAD);

   // framing state
   fscdf_pkg::phase_type phase_ff, phase_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] kind_ff, kind_in;
   logic [7:0] exp_ff, exp_in;
   fscdf_pkg::status_type st_in;

   // output stage
   logic                  out_valid_ff;
   fscdf_pkg::status_type out_st_ff;
   logic [7:0]            out_len_ff;
   logic                  skid_valid_ff;
   fscdf_pkg::status_type skid_st_ff;
   logic [7:0]            skid_len_ff;

   logic                  accept;
   logic [7:0]            c;
   fscdf_pkg::hex_type    hx;
   logic [7:0]            exp_full;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign hx         = fscdf_pkg::hex_decode(c);
   assign exp_full   = {exp_ff[7:4], hx.nib};

   // next framing state and beat status
   always_comb begin
      phase_in = phase_ff;
      xor_in   = xor_ff;
      count_in = count_ff;
      kind_in  = kind_ff;
      exp_in   = exp_ff;
      st_in    = fscdf_pkg::ST_FAIL;
      unique case (phase_ff)
         fscdf_pkg::PH_REC: begin
            if (c == fscdf_pkg::ChStar) begin
               phase_in = fscdf_pkg::PH_HEX1;
               st_in    = fscdf_pkg::ST_GOOD;
            end else if (count_ff >= MaxPayloadLim) begin
               phase_in = fscdf_pkg::PH_WAIT;
            end else begin
               xor_in   = xor_ff ^ c;
               if (count_ff == 8'd1) kind_in = c;
               count_in = count_ff + 8'd1;
               st_in    = fscdf_pkg::ST_GOOD;
            end
         end
         fscdf_pkg::PH_HEX1: begin
            if (hx.ok) begin
               exp_in   = {hx.nib, 4'd0};
               phase_in = fscdf_pkg::PH_HEX2;
               st_in    = fscdf_pkg::ST_GOOD;
            end else begin
               phase_in = fscdf_pkg::PH_WAIT;
            end
         end
         fscdf_pkg::PH_HEX2: begin
            phase_in = fscdf_pkg::PH_WAIT;
            if (hx.ok) begin
               exp_in = exp_full;
               if (exp_full == xor_ff) begin
                  phase_in = fscdf_pkg::PH_NL;
                  st_in    = fscdf_pkg::ST_GOOD;
               end
            end
         end
         fscdf_pkg::PH_NL: begin
            phase_in = fscdf_pkg::PH_WAIT;
            st_in    = (c == fscdf_pkg::ChNewline) ? fscdf_pkg::classify(kind_ff)
                                                   : fscdf_pkg::ST_FAIL;
         end
         default: begin
            if (c == fscdf_pkg::ChStart) begin
               xor_in   = 8'd0;
               count_in = 8'd0;
               kind_in  = 8'd0;
               exp_in   = 8'd0;
               phase_in = fscdf_pkg::PH_REC;
               st_in    = fscdf_pkg::ST_GOOD;
            end else begin
               phase_in = fscdf_pkg::PH_WAIT;
               st_in    = fscdf_pkg::ST_WAITING;
            end
         end
      endcase
   end

   // framing state registers, advance on each taken beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fscdf_pkg::PH_WAIT;
         xor_ff   <= 8'd0;
         count_ff <= 8'd0;
         kind_ff  <= 8'd0;
         exp_ff   <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         xor_ff   <= xor_in;
         count_ff <= count_in;
         kind_ff  <= kind_in;
         exp_ff   <= exp_in;
      end
   end

   // output register and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         if (!out_valid_ff || rsp_tready) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_valid_ff && rsp_tready) begin
         out_valid_ff  <= skid_valid_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         if (!out_valid_ff || rsp_tready) begin
            out_st_ff  <= st_in;
            out_len_ff <= count_in;
         end else begin
            skid_st_ff  <= st_in;
            skid_len_ff <= count_in;
         end
      end else if (out_valid_ff && rsp_tready && skid_valid_ff) begin
         out_st_ff  <= skid_st_ff;
         out_len_ff <= skid_len_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_len_ff, out_st_ff};

   // checks
   `ASSERT_CLK(a_skid_behind_out, clock, reset, skid_valid_ff |-> out_valid_ff, "skid entry held with empty output register")
   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= MaxPayloadLim, "payload count above limit")
   `ASSERT_CLK(a_start_clears, clock, reset, (accept && phase_ff == fscdf_pkg::PH_WAIT && c == fscdf_pkg::ChStart) |=> (count_ff == 8'd0 && xor_ff == 8'd0 && phase_ff == fscdf_pkg::PH_REC), "start character did not open a clean sentence")
   `ASSERT_ALWAYS(a_reset_wait, clock, reset |=> (phase_ff == fscdf_pkg::PH_WAIT && !out_valid_ff && !skid_valid_ff), "reset did not return to waiting")

endmodule
